// ===== hw/rtl/htlp_pkg.sv =====
// ----------------------------------------------------------------------------
// Haplotype transition log probabilities: shared package
// Constants, state codes and the structs that pass between the block's parts.
// ----------------------------------------------------------------------------
`default_nettype none

package htlp_pkg;

   localparam int GAP_W     = 48;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW   = 2;

   localparam logic [63:0] Q63_ONE = 64'h8000000000000000;
   localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AB;
   localparam logic [63:0] LN2_Q56 = 64'h00B17217F7D1CF79;
   localparam logic [31:0] MAG_SAT = 32'h80000000;
   localparam logic [64:0] RECIP_NUM = 65'h1_0000_0000_0000_0000;

   localparam logic [1:0] CSR_POP_SCALE     = 2'd0;
   localparam logic [1:0] CSR_SMOOTH_FACTOR = 2'd1;
   localparam logic [1:0] CSR_HAP_COUNT     = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PG,
      ST_XDIV,
      ST_EK,
      ST_EH_M,
      ST_EH_D,
      ST_EH_C,
      ST_EDR,
      ST_DN,
      ST_LN,
      ST_LF,
      ST_LM,
      ST_SM,
      ST_CMP,
      ST_OUT
   } st_type;

   typedef enum logic [1:0] {
      LOG_D,
      LOG_N,
      LOG_S,
      LOG_Q
   } log_sel_type;

   typedef struct packed {
      logic             vld;
      logic [GAP_W-1:0] gap;
   } gap_beat_type;

   typedef struct packed {
      logic [31:0] pop_scale;
      logic [31:0] smooth_factor;
      logic [15:0] hap_count;
   } cfg_type;

   // Floor of 2^64 / j for the series divisors; the quotient estimate taken
   // with it is low by at most one.
   function automatic logic [63:0] horner_recip(input logic [4:0] j);
      logic [63:0] m;
      case (j)
         5'd2:    m = 64'(RECIP_NUM / 65'd2);
         5'd3:    m = 64'(RECIP_NUM / 65'd3);
         5'd4:    m = 64'(RECIP_NUM / 65'd4);
         5'd5:    m = 64'(RECIP_NUM / 65'd5);
         5'd6:    m = 64'(RECIP_NUM / 65'd6);
         5'd7:    m = 64'(RECIP_NUM / 65'd7);
         5'd8:    m = 64'(RECIP_NUM / 65'd8);
         5'd9:    m = 64'(RECIP_NUM / 65'd9);
         5'd10:   m = 64'(RECIP_NUM / 65'd10);
         5'd11:   m = 64'(RECIP_NUM / 65'd11);
         5'd12:   m = 64'(RECIP_NUM / 65'd12);
         5'd13:   m = 64'(RECIP_NUM / 65'd13);
         5'd14:   m = 64'(RECIP_NUM / 65'd14);
         5'd15:   m = 64'(RECIP_NUM / 65'd15);
         5'd16:   m = 64'(RECIP_NUM / 65'd16);
         5'd17:   m = 64'(RECIP_NUM / 65'd17);
         5'd18:   m = 64'(RECIP_NUM / 65'd18);
         5'd19:   m = 64'(RECIP_NUM / 65'd19);
         5'd20:   m = 64'(RECIP_NUM / 65'd20);
         5'd21:   m = 64'(RECIP_NUM / 65'd21);
         5'd22:   m = 64'(RECIP_NUM / 65'd22);
         5'd23:   m = 64'(RECIP_NUM / 65'd23);
         5'd24:   m = 64'(RECIP_NUM / 65'd24);
         5'd25:   m = 64'(RECIP_NUM / 65'd25);
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/htlp_front.sv =====
// ----------------------------------------------------------------------------
// Front end
// Takes marker beats, keeps the previous position and queues the map gap of
// every marker that is not the first of its chromosome.
// ----------------------------------------------------------------------------
`default_nettype none

module htlp_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [47:0]         req_tdata,   // map_pos
   input  wire logic                req_tuser,   // first_marker
   output htlp_pkg::gap_beat_type   push,
   input  wire logic                push_ready
);
   import htlp_pkg::*;

   logic [GAP_W-1:0] prev_ff;
   logic [GAP_W-1:0] prev_in;
   logic             take;

   assign req_tready = push_ready;
   assign take       = req_tvalid & push_ready;

   always_comb begin
      prev_in  = prev_ff;
      push.vld = 1'b0;
      push.gap = GAP_W'(1);
      if (take) begin
         prev_in = req_tdata;
         push.vld = ~req_tuser;
         // A gap of zero or less is floored at one LSB.
         if (req_tdata > prev_ff) begin
            push.gap = req_tdata - prev_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/htlp_fifo.sv =====
// ----------------------------------------------------------------------------
// Gap queue
// Short queue of map gaps between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module htlp_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  htlp_pkg::gap_beat_type push,
   output logic                   push_ready,
   output htlp_pkg::gap_beat_type head,
   input  wire logic              pop
);
   import htlp_pkg::*;

   logic [GAP_W-1:0]   mem [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wp_ff, wp_in;
   logic [FIFO_AW-1:0] rp_ff, rp_in;
   logic [FIFO_AW:0]   cnt_ff, cnt_in;
   logic               do_push, do_pop;

   assign push_ready = (cnt_ff != (FIFO_AW+1)'(FIFO_DEPTH));
   assign do_push    = push.vld & push_ready;
   assign do_pop     = pop & (cnt_ff != '0);
   assign head.vld   = (cnt_ff != '0);
   assign head.gap   = mem[rp_ff];

   always_comb begin
      wp_in  = do_push ? wp_ff + FIFO_AW'(1) : wp_ff;
      rp_in  = do_pop ? rp_ff + FIFO_AW'(1) : rp_ff;
      cnt_in = cnt_ff + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wp_ff] <= push.gap;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/htlp_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// 64 x 64 bit unsigned product from four 32 x 32 bit partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module htlp_mul (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   output logic             done,
   output logic [127:0]     prod
);
   logic [63:0]  a_ff, b_ff, a_in, b_in;
   logic [63:0]  pp_ff, pp_in;
   logic [127:0] acc_ff, acc_in;
   logic [2:0]   ph_ff, ph_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [31:0]  ha, hb;
   logic [6:0]   sh;

   assign done = done_ff;
   assign prod = acc_ff;

   always_comb begin
      ha = ph_ff[1] ? a_ff[63:32] : a_ff[31:0];
      hb = ph_ff[0] ? b_ff[63:32] : b_ff[31:0];
      // Shift for the partial product formed in the previous phase.
      case (ph_ff)
         3'd1:    sh = 7'd0;
         3'd2:    sh = 7'd32;
         3'd3:    sh = 7'd32;
         default: sh = 7'd64;
      endcase
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      pp_in   = pp_ff;
      acc_in  = acc_ff;
      ph_in   = ph_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
         ph_in   = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ph_ff != 3'd4) begin
            pp_in = {32'd0, ha} * {32'd0, hb};
         end
         if (ph_ff != 3'd0) begin
            acc_in = acc_ff + ({64'd0, pp_ff} << sh);
         end
         ph_in = ph_ff + 3'd1;
         if (ph_ff == 3'd4) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         ph_ff   <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         ph_ff   <= ph_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/htlp_div.sv =====
// ----------------------------------------------------------------------------
// Shared divider
// Restoring division of a 64-bit dividend by a 16-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module htlp_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             done,
   output logic [63:0]      quo,
   output logic [15:0]      rem
);
   logic [63:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;
   logic [16:0] diff;
   logic        ge;

   assign done = done_ff;
   assign quo  = quo_ff;
   assign rem  = rem_ff;

   always_comb begin
      trial = {rem_ff, quo_ff[63]};
      ge    = (trial >= {1'b0, dvs_ff});
      diff  = trial - {1'b0, dvs_ff};
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // The partial remainder stays below the divisor, so 16 bits hold it.
         rem_in = ge ? diff[15:0] : trial[15:0];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/htlp_back.sv =====
// ----------------------------------------------------------------------------
// Back end
// Sequencer that turns one queued map gap into the three log transition
// values, using the shared multiplier and divider, and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module htlp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  htlp_pkg::cfg_type      cfg,
   input  htlp_pkg::gap_beat_type head,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [95:0]            rsp_tdata  // log_switch, log_stay, log_stay_only
);
   import htlp_pkg::*;

   st_type       st_ff, st_in;
   logic         pend_ff, pend_in;
   logic [127:0] vx_ff, vx_in;
   logic [15:0]  xr_ff, xr_in;
   logic [1:0]   lb_ff, lb_in;
   logic [63:0]  er_ff, er_in;
   logic [8:0]   ek_ff, ek_in;
   logic [3:0]   kb_ff, kb_in;
   logic [63:0]  t_ff, t_in;
   logic [4:0]   jj_ff, jj_in;
   logic [63:0]  tp_ff, tp_in;
   logic [63:0]  ee_ff, ee_in;
   logic [63:0]  ed_ff, ed_in;
   logic         esec_ff, esec_in;
   logic [63:0]  s_ff, s_in;
   logic [63:0]  lv_ff, lv_in;
   logic [5:0]   lc_ff, lc_in;
   logic [4:0]   li_ff, li_in;
   logic [31:0]  fr_ff, fr_in;
   log_sel_type  lsel_ff, lsel_in;
   logic [63:0]  mag_ff, mag_in;
   logic         ssel_ff, ssel_in;
   logic [31:0]  dmag_ff, dmag_in;
   logic [31:0]  smag_ff, smag_in;
   logic [31:0]  pmag_ff, pmag_in;
   logic         ovld_ff, ovld_in;
   logic [95:0]  od_ff, od_in;

   logic         mstart, mdone;
   logic [63:0]  ma, mb;
   logic [127:0] mprod;
   logic         dstart, ddone;
   logic [63:0]  da, dquo;
   logic [15:0]  db, drem;

   htlp_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mstart),
      .a     (ma),
      .b     (mb),
      .done  (mdone),
      .prod  (mprod)
   );

   htlp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dstart),
      .dividend (da),
      .divisor  (db),
      .done     (ddone),
      .quo      (dquo),
      .rem      (drem)
   );

   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = od_ff;

   always_comb begin
      logic [15:0]  n;
      logic [63:0]  r;
      logic [63:0]  cmp;
      logic [63:0]  dr, em, xv;
      logic [127:0] vsh, pr;
      logic [63:0]  l2, res, t1, t2;
      logic [63:0]  rr, qc;
      logic [31:0]  y;
      logic         lfin;
      logic [63:0]  lval;

      n    = (cfg.hap_count == 16'd0) ? 16'd1 : cfg.hap_count;
      r    = {er_ff[56:0], 7'd0};
      cmp  = LN2_Q56 << kb_ff;
      dr   = '0;
      em   = '0;
      xv   = '0;
      vsh  = '0;
      pr   = '0;
      l2   = '0;
      res  = '0;
      t1   = '0;
      t2   = '0;
      rr   = '0;
      qc   = '0;
      y    = '0;
      lfin = 1'b0;
      lval = '0;

      st_in   = st_ff;
      pend_in = pend_ff;
      vx_in   = vx_ff;
      xr_in   = xr_ff;
      lb_in   = lb_ff;
      er_in   = er_ff;
      ek_in   = ek_ff;
      kb_in   = kb_ff;
      t_in    = t_ff;
      jj_in   = jj_ff;
      tp_in   = tp_ff;
      ee_in   = ee_ff;
      ed_in   = ed_ff;
      esec_in = esec_ff;
      s_in    = s_ff;
      lv_in   = lv_ff;
      lc_in   = lc_ff;
      li_in   = li_ff;
      fr_in   = fr_ff;
      lsel_in = lsel_ff;
      mag_in  = mag_ff;
      ssel_in = ssel_ff;
      dmag_in = dmag_ff;
      smag_in = smag_ff;
      pmag_in = pmag_ff;
      ovld_in = ovld_ff & ~rsp_tready;
      od_in   = od_ff;

      mstart = 1'b0;
      ma     = '0;
      mb     = '0;
      dstart = 1'b0;
      da     = '0;
      db     = '0;
      pop    = 1'b0;

      case (st_ff)
         ST_IDLE: begin
            if (head.vld) begin
               st_in = ST_PG;
            end
         end

         ST_PG: begin
            ma = {32'd0, cfg.pop_scale};
            mb = {16'd0, head.gap};
            if (!pend_ff) begin
               mstart  = 1'b1;
               pop     = 1'b1;
               pend_in = 1'b1;
            end else if (mdone) begin
               pend_in = 1'b0;
               vx_in   = {mprod[117:0], 10'd0};
               xr_in   = '0;
               lb_in   = '0;
               st_in   = ST_XDIV;
            end
         end

         // Long division of the scaled product by the haplotype count,
         // 32 bits at a time from the top.
         ST_XDIV: begin
            da = {16'd0, xr_ff, vx_ff[127:96]};
            db = n;
            if (!pend_ff) begin
               dstart  = 1'b1;
               pend_in = 1'b1;
            end else if (ddone) begin
               pend_in = 1'b0;
               vsh     = {vx_ff[95:0], dquo[31:0]};
               vx_in   = vsh;
               xr_in   = drem;
               lb_in   = lb_ff + 2'd1;
               if (lb_ff == 2'd3) begin
                  xv      = (vsh[127:64] != 64'd0) ? '1 : vsh[63:0];
                  er_in   = xv;
                  ek_in   = '0;
                  kb_in   = 4'd8;
                  esec_in = 1'b0;
                  st_in   = ST_EK;
               end
            end
         end

         // Range reduction: x = k * ln2 + rest, one bit of k per cycle.
         ST_EK: begin
            if (er_ff >= cmp) begin
               er_in = er_ff - cmp;
               ek_in = ek_ff | (9'd1 << kb_ff);
            end
            kb_in = kb_ff - 4'd1;
            if (kb_ff == 4'd0) begin
               t_in  = Q63_ONE;
               jj_in = 5'd25;
               st_in = ST_EH_M;
            end
         end

         ST_EH_M: begin
            ma = r;
            mb = t_ff;
            if (!pend_ff) begin
               mstart  = 1'b1;
               pend_in = 1'b1;
            end else if (mdone) begin
               pend_in = 1'b0;
               tp_in   = mprod[126:63];
               st_in   = ST_EH_D;
            end
         end

         // Division by the series index through its reciprocal; the estimate
         // is fixed up by one in the next state.
         ST_EH_D: begin
            ma = tp_ff;
            mb = horner_recip(jj_ff);
            if (!pend_ff) begin
               mstart  = 1'b1;
               pend_in = 1'b1;
            end else if (mdone) begin
               pend_in = 1'b0;
               t_in    = mprod[127:64];
               st_in   = ST_EH_C;
            end
         end

         ST_EH_C: begin
            ma = t_ff;
            mb = {59'd0, jj_ff};
            if (!pend_ff) begin
               mstart  = 1'b1;
               pend_in = 1'b1;
            end else if (mdone) begin
               pend_in = 1'b0;
               rr      = tp_ff - mprod[63:0];
               qc      = (rr >= {59'd0, jj_ff}) ? t_ff + 64'd1 : t_ff;
               t_in    = Q63_ONE - qc;
               jj_in   = jj_ff - 5'd1;
               st_in   = (jj_ff == 5'd2) ? ST_EDR : ST_EH_M;
            end
         end

         ST_EDR: begin
            ma = r;
            mb = t_ff;
            if (!pend_ff) begin
               mstart  = 1'b1;
               pend_in = 1'b1;
            end else if (mdone) begin
               pend_in = 1'b0;
               dr      = mprod[126:63];
               if (dr > Q63_ONE) begin
                  dr = Q63_ONE;
               end
               em = Q63_ONE - dr;
               if (ek_ff == 9'd0) begin
                  ed_in = dr;
                  ee_in = em;
               end else if (ek_ff[8:6] != 3'd0) begin
                  ee_in = '0;
                  ed_in = Q63_ONE;
               end else begin
                  ee_in = em >> ek_ff[5:0];
                  ed_in = Q63_ONE - (em >> ek_ff[5:0]);
               end
               if (esec_ff) begin
                  if (ed_in == 64'd0) begin
                     pmag_in = MAG_SAT;
                     st_in   = ST_OUT;
                  end else begin
                     lv_in   = ed_in;
                     lc_in   = '0;
                     lsel_in = LOG_Q;
                     st_in   = ST_LN;
                  end
               end else begin
                  st_in = ST_DN;
               end
            end
         end

         ST_DN: begin
            da = ed_ff;
            db = n;
            if (!pend_ff) begin
               dstart  = 1'b1;
               pend_in = 1'b1;
            end else if (ddone) begin
               pend_in = 1'b0;
               s_in    = ee_ff + dquo;
               lc_in   = '0;
               st_in   = ST_LN;
               if (ed_ff == 64'd0) begin
                  // Log of zero: switch saturates whatever the smoothing is.
                  dmag_in = MAG_SAT;
                  lv_in   = ee_ff + dquo;
                  lsel_in = LOG_S;
               end else begin
                  lv_in   = ed_ff;
                  lsel_in = LOG_D;
               end
            end
         end

         // Normalize so the top bit is set, one place per cycle.
         ST_LN: begin
            if (lv_ff[63] || lc_ff == 6'd63) begin
               if (lsel_ff != LOG_N && lc_ff == 6'd0) begin
                  lfin = 1'b1;
                  lval = '0;
               end else begin
                  li_in = '0;
                  st_in = ST_LF;
               end
            end else begin
               lv_in = {lv_ff[62:0], 1'b0};
               lc_in = lc_ff + 6'd1;
            end
         end

         // Fraction of log2 by repeated squaring, one bit per product.
         ST_LF: begin
            ma = lv_ff;
            mb = lv_ff;
            if (!pend_ff) begin
               mstart  = 1'b1;
               pend_in = 1'b1;
            end else if (mdone) begin
               pend_in = 1'b0;
               fr_in   = {fr_ff[30:0], mprod[127]};
               lv_in   = mprod[127] ? mprod[127:64] : mprod[126:63];
               li_in   = li_ff + 5'd1;
               if (li_ff == 5'd31) begin
                  st_in = ST_LM;
               end
            end
         end

         ST_LM: begin
            if (lsel_ff == LOG_N) begin
               l2 = {26'd0, 6'd63 - lc_ff, fr_ff};
            end else begin
               l2 = {26'd0, lc_ff, 32'd0} - {32'd0, fr_ff};
            end
            ma = l2;
            mb = LN2_Q64;
            if (!pend_ff) begin
               mstart  = 1'b1;
               pend_in = 1'b1;
            end else if (mdone) begin
               pend_in = 1'b0;
               lfin    = 1'b1;
               lval    = mprod[127:64];
            end
         end

         // Smoothing product, rounded half up to Q.24 and saturated.
         ST_SM: begin
            ma = mag_ff;
            mb = {32'd0, cfg.smooth_factor};
            if (!pend_ff) begin
               mstart  = 1'b1;
               pend_in = 1'b1;
            end else if (mdone) begin
               pend_in = 1'b0;
               pr      = mprod + 128'h80000000;
               res     = pr[95:32];
               if (pr[127:95] != 33'd0 || res > {32'd0, MAG_SAT}) begin
                  res = {32'd0, MAG_SAT};
               end
               if (!ssel_ff) begin
                  dmag_in = res[31:0];
                  lv_in   = s_ff;
                  lc_in   = '0;
                  lsel_in = LOG_S;
                  st_in   = ST_LN;
               end else begin
                  smag_in = res[31:0];
                  st_in   = ST_CMP;
               end
            end
         end

         ST_CMP: begin
            if (dmag_ff <= smag_ff) begin
               pmag_in = MAG_SAT;
               st_in   = ST_OUT;
            end else begin
               y       = dmag_ff - smag_ff;
               er_in   = {y, 32'd0};
               ek_in   = '0;
               kb_in   = 4'd8;
               esec_in = 1'b1;
               st_in   = ST_EK;
            end
         end

         ST_OUT: begin
            if (!ovld_ff || rsp_tready) begin
               ovld_in = 1'b1;
               od_in   = {32'd0 - pmag_ff, 32'd0 - smag_ff, 32'd0 - dmag_ff};
               st_in   = ST_IDLE;
            end
         end

         default: begin
            st_in = ST_IDLE;
         end
      endcase

      if (lfin) begin
         case (lsel_ff)
            LOG_D: begin
               mag_in  = lval;
               lv_in   = {48'd0, n};
               lc_in   = '0;
               lsel_in = LOG_N;
               st_in   = ST_LN;
            end
            LOG_N: begin
               mag_in  = mag_ff + lval;
               ssel_in = 1'b0;
               st_in   = ST_SM;
            end
            LOG_S: begin
               mag_in  = lval;
               ssel_in = 1'b1;
               st_in   = ST_SM;
            end
            default: begin
               t1 = lval + 64'd128;
               t2 = {8'd0, t1[63:8]} + {32'd0, smag_ff};
               pmag_in = (t2 > {32'd0, MAG_SAT}) ? MAG_SAT : t2[31:0];
               st_in   = ST_OUT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         pend_ff <= 1'b0;
         ovld_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         pend_ff <= pend_in;
         ovld_ff <= ovld_in;
      end
   end

   always_ff @(posedge clock) begin
      vx_ff   <= vx_in;
      xr_ff   <= xr_in;
      lb_ff   <= lb_in;
      er_ff   <= er_in;
      ek_ff   <= ek_in;
      kb_ff   <= kb_in;
      t_ff    <= t_in;
      jj_ff   <= jj_in;
      tp_ff   <= tp_in;
      ee_ff   <= ee_in;
      ed_ff   <= ed_in;
      esec_ff <= esec_in;
      s_ff    <= s_in;
      lv_ff   <= lv_in;
      lc_ff   <= lc_in;
      li_ff   <= li_in;
      fr_ff   <= fr_in;
      lsel_ff <= lsel_in;
      mag_ff  <= mag_in;
      ssel_ff <= ssel_in;
      dmag_ff <= dmag_in;
      smag_ff <= smag_in;
      pmag_ff <= pmag_in;
      od_ff   <= od_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/haplotype_transition_log_probs.sv =====
// ----------------------------------------------------------------------------
// Haplotype transition log probabilities
// The back end handles one queued gap at a time, with about 280 uses of the shared
// multiplier and five of the divider per marker; the next gap waits in the queue.
// A first marker gives no result; four gaps can queue.
// Synchronous reset clears the previous position, queue, sequencer and
// registers to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module haplotype_transition_log_probs (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // map_pos
   input  wire logic        req_tuser,   // first_marker
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,   // log_switch, log_stay, log_stay_only
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_addr,
   input  wire logic [31:0] csr_wdata
);
   import htlp_pkg::*;

   cfg_type      cfg_ff, cfg_in;
   gap_beat_type push;
   gap_beat_type head;
   logic         push_ready;
   logic         pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            CSR_POP_SCALE:     cfg_in.pop_scale     = csr_wdata;
            CSR_SMOOTH_FACTOR: cfg_in.smooth_factor = csr_wdata;
            CSR_HAP_COUNT:     cfg_in.hap_count     = csr_wdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pop_scale     <= 32'd16777;
         cfg_ff.smooth_factor <= 32'd16777216;
         cfg_ff.hap_count     <= 16'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   htlp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push       (push),
      .push_ready (push_ready)
   );

   htlp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .head       (head),
      .pop        (pop)
   );

   htlp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
